/* rtl/core/uibh_pkg.sv */
// Shared types, constants and checksum helpers for the IPv4/UDP broadcast
// header builder. No dependencies; used by every module of the block.

package uibh_pkg;

   // payload limit and fixed header sizes
   localparam logic [15:0] MAX_PAYLOAD    = 16'd65507;
   localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
   localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
   localparam logic [15:0] PROTO_UDP      = 16'd17;
   localparam logic [15:0] UDP_PORT_RESET = 16'd654;

   // port widths
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 80;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UDP_PORT       = 1'd1;

   // width of the unfolded checksum sums
   localparam int SUM_W = 20;

   // fixed IPv4 header words: version/IHL, id, protocol low byte, broadcast
   // destination (two all-ones words), and the 28-byte length offset
   localparam logic [SUM_W-1:0] IP_SUM_CONST =
      20'h04500 + 20'h00001 + 20'h00011 + 20'h0FFFF + 20'h0FFFF
      + 20'd28;

   // pseudo header destination, protocol, plus both UDP length offsets
   localparam logic [SUM_W-1:0] UDP_SUM_CONST =
      20'h0FFFF + 20'h0FFFF + 20'h00011 + 20'd16;

   // one finished message handed from the accumulator to the header stage
   typedef struct packed {
      logic [15:0] sum;       // folded payload sum, odd byte padded
      logic [15:0] count;     // accepted payload bytes
      logic [7:0]  ttl;       // time-to-live from the last item
      logic        too_long;  // bytes beyond the limit were dropped
   } msg_type;

   // end-around carry fold of a wide sum down to 16 bits
   function automatic logic [15:0] fold20(input logic [SUM_W-1:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {13'd0, s[SUM_W-1:16]};
      fold20 = t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

/* rtl/core/uibh_accum.sv */
// Input register and running payload accumulator: sum, byte count and
// pending high byte. Depends on uibh_pkg.

module uibh_accum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [uibh_pkg::REQ_DATA_W-1:0] req_tdata,  // payload_byte, hop_limit
   input  logic                            req_tlast,  // last_byte
   output logic                            msg_valid,
   input  logic                            msg_ready,
   output uibh_pkg::msg_type               msg
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_ttl_ff;
   logic       in_last_ff;

   // message state
   logic [15:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  hold_ff, hold_in;
   logic        ovf_ff, ovf_in;

   // finished message slot
   logic              msg_vld_ff, msg_vld_in;
   uibh_pkg::msg_type msg_ff, msg_in;

   logic        take_in, acc_take, msg_free, full;
   logic [15:0] word, folded, count_next;
   logic [16:0] wsum;

   // handshake between input register, accumulator and message slot
   assign msg_free   = !msg_vld_ff || msg_ready;
   assign acc_take   = in_vld_ff && (!in_last_ff || msg_free);
   assign req_tready = !in_vld_ff || acc_take;
   assign take_in    = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (take_in) begin
         in_vld_in = 1'b1;
      end else if (acc_take) begin
         in_vld_in = 1'b0;
      end
   end

   // one add with end-around carry covers both word completion and the
   // zero-padded odd byte of the final sum
   assign full = count_ff >= uibh_pkg::MAX_PAYLOAD;
   always_comb begin
      if (full) begin
         word = {hold_ff, 8'h00};
      end else if (count_ff[0]) begin
         word = {hold_ff, in_byte_ff};
      end else begin
         word = {in_byte_ff, 8'h00};
      end
   end
   assign wsum       = {1'b0, sum_ff} + {1'b0, word};
   assign folded     = wsum[15:0] + {15'd0, wsum[16]};
   assign count_next = full ? count_ff : count_ff + 16'd1;

   // state update per item; cleared after the last item
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      hold_in  = hold_ff;
      ovf_in   = ovf_ff;
      if (acc_take) begin
         if (in_last_ff) begin
            sum_in   = '0;
            count_in = '0;
            hold_in  = '0;
            ovf_in   = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_next;
            if (count_ff[0]) begin
               sum_in  = folded;
               hold_in = '0;
            end else begin
               hold_in = in_byte_ff;
            end
         end
      end
   end

   // message slot load
   always_comb begin
      msg_vld_in = msg_vld_ff;
      msg_in     = msg_ff;
      if (acc_take && in_last_ff) begin
         msg_vld_in      = 1'b1;
         msg_in.sum      = folded;
         msg_in.count    = count_next;
         msg_in.ttl      = in_ttl_ff;
         msg_in.too_long = ovf_ff || full;
      end else if (msg_ready) begin
         msg_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         msg_vld_ff <= 1'b0;
         sum_ff     <= '0;
         count_ff   <= '0;
         hold_ff    <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         msg_vld_ff <= msg_vld_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         hold_ff    <= hold_in;
         ovf_ff     <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff <= req_tdata[7:0];
         in_ttl_ff  <= req_tdata[15:8];
         in_last_ff <= req_tlast;
      end
      msg_ff <= msg_in;
   end

   assign msg_valid = msg_vld_ff;
   assign msg       = msg_ff;

endmodule

/* rtl/core/uibh_header.sv */
// Header field stage: lengths and both checksums from one finished message,
// held in the result register. Depends on uibh_pkg.

module uibh_header (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            msg_valid,
   output logic                            msg_ready,
   input  uibh_pkg::msg_type               msg,
   input  logic [31:0]                     source_address,
   input  logic [15:0]                     udp_port,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // ip_total_length, ip_header_checksum, udp_length, udp_checksum,
   // ttl_used, too_long, zero fill
   output logic [uibh_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                            rsp_vld_ff, rsp_vld_in;
   logic [uibh_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [15:0]               ip_len, udp_len, ip_ck, udp_fold, udp_ck;
   logic [uibh_pkg::SUM_W-1:0] ip_sum, udp_sum;

   assign msg_ready = !rsp_vld_ff || rsp_tready;

   // lengths; the count never exceeds the payload limit, so no wrap
   assign ip_len  = msg.count + uibh_pkg::IP_HDR_BYTES + uibh_pkg::UDP_HDR_BYTES;
   assign udp_len = msg.count + uibh_pkg::UDP_HDR_BYTES;

   // IPv4 header sum: the length word is the count plus its offset constant
   assign ip_sum = {4'd0, msg.count} + {4'd0, msg.ttl, 8'h00}
                 + {4'd0, source_address[31:16]} + {4'd0, source_address[15:0]}
                 + uibh_pkg::IP_SUM_CONST;
   assign ip_ck  = ~uibh_pkg::fold20(ip_sum);

   // pseudo header, UDP header and payload; length and port appear twice
   assign udp_sum = {4'd0, msg.sum}
                  + {4'd0, source_address[31:16]} + {4'd0, source_address[15:0]}
                  + {3'd0, msg.count, 1'b0} + {3'd0, udp_port, 1'b0}
                  + uibh_pkg::UDP_SUM_CONST;
   assign udp_fold = ~uibh_pkg::fold20(udp_sum);
   // a computed zero goes out as all ones
   assign udp_ck   = (udp_fold == 16'h0000) ? 16'hFFFF : udp_fold;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (msg_valid && msg_ready) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (msg_valid && msg_ready) begin
         rsp_data_ff <= {7'd0, msg.too_long, msg.ttl, udp_ck, udp_len, ip_ck, ip_len};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/udp_ip_broadcast_header_builder.sv */
// Top level of the IPv4/UDP broadcast header builder: configuration
// registers, accumulator and header stage. Depends on uibh_pkg, uibh_accum
// and uibh_header.
// Throughput: one payload item per cycle, limited by the running sum add;
// a last item waits while the message slot is full. The last item passes
// the input register, message slot and result register to rsp_tvalid.
// Reset: synchronous; clears the message state, empties all stages and
// sets source_address to 0 and udp_port to 654.

module udp_ip_broadcast_header_builder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [uibh_pkg::REQ_DATA_W-1:0]  req_tdata,  // payload_byte, hop_limit
   input  logic                             req_tlast,  // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // ip_total_length, ip_header_checksum, udp_length, udp_checksum,
   // ttl_used, too_long, zero fill
   output logic [uibh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [uibh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uibh_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0] src_addr_ff, src_addr_in;
   logic [15:0] port_ff, port_in;

   logic              msg_valid, msg_ready;
   uibh_pkg::msg_type msg;

   // register write decode
   always_comb begin
      src_addr_in = src_addr_ff;
      port_in     = port_ff;
      if (csr_we) begin
         unique case (csr_index)
            uibh_pkg::REG_SOURCE_ADDRESS: src_addr_in = csr_wdata;
            uibh_pkg::REG_UDP_PORT:       port_in     = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff <= '0;
         port_ff     <= uibh_pkg::UDP_PORT_RESET;
      end else begin
         src_addr_ff <= src_addr_in;
         port_ff     <= port_in;
      end
   end

   uibh_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .msg_valid  (msg_valid),
      .msg_ready  (msg_ready),
      .msg        (msg)
   );

   uibh_header u_header (
      .clock          (clock),
      .reset          (reset),
      .msg_valid      (msg_valid),
      .msg_ready      (msg_ready),
      .msg            (msg),
      .source_address (src_addr_ff),
      .udp_port       (port_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

/* rtl/core/uibh_checker.sv */
// Port-level checks for the IPv4/UDP broadcast header builder, bound to the
// top level. Depends on uibh_pkg.

module uibh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [uibh_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // both lengths come from the same byte count
   a_len_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == rsp_tdata[47:32] + uibh_pkg::IP_HDR_BYTES)
      else $error("IP and UDP lengths disagree");

   // a zero UDP checksum is never sent
   a_udp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:48] != 16'h0000)
      else $error("zero UDP checksum sent");

   // a saturated payload reports the largest total length
   a_sat_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[72] |-> rsp_tdata[15:0] == 16'hFFFF)
      else $error("too_long without saturated length");

endmodule

bind udp_ip_broadcast_header_builder uibh_checker u_checker (.*);
